// ----- rtl/eti_pkg.sv -----
// Shared constants, control-word type and microprogram for the escape-time iterator.
// Depends on nothing; imported by the channel interfaces and the top level.
package eti_pkg;

	localparam int FRAC_BITS   = 28;
	localparam int COUNT_WIDTH = 16;
	localparam int Q_WIDTH     = 32;
	localparam int PROD_WIDTH  = 2 * Q_WIDTH;
	localparam int PS_WIDTH    = 4;
	localparam int LIMIT_WIDTH = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int PC_WIDTH    = 4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POWER_STEPS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LIMIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_LIMIT  = 2'd2;

	localparam logic [PS_WIDTH-1:0]    PS_RESET   = 4'd2;
	localparam logic [LIMIT_WIDTH-1:0] MAX_RESET  = 16'd256;
	localparam logic [LIMIT_WIDTH-1:0] VIEW_RESET = 16'd50;

	// Multiplier operand selection
	localparam logic [1:0] MUL_NONE = 2'd0;
	localparam logic [1:0] MUL_RR   = 2'd1;
	localparam logic [1:0] MUL_II   = 2'd2;
	localparam logic [1:0] MUL_RI   = 2'd3;

	// Accumulator operation
	localparam logic [1:0] ACC_HOLD   = 2'd0;
	localparam logic [1:0] ACC_LOAD   = 2'd1;
	localparam logic [1:0] ACC_SUB    = 2'd2;
	localparam logic [1:0] ACC_LOADSH = 2'd3;

	// Working value update
	localparam logic [1:0] N_HOLD   = 2'd0;
	localparam logic [1:0] N_FROM_Z = 2'd1;
	localparam logic [1:0] N_SQ     = 2'd2;
	localparam logic [1:0] N_ADDC   = 2'd3;

	// Sequencer conditions
	localparam logic [2:0] C_NEXT    = 3'd0;
	localparam logic [2:0] C_WAIT_IN = 3'd1;
	localparam logic [2:0] C_LIMIT   = 3'd2;
	localparam logic [2:0] C_SQ_ZERO = 3'd3;
	localparam logic [2:0] C_SQ_MORE = 3'd4;
	localparam logic [2:0] C_INSIDE  = 3'd5;
	localparam logic [2:0] C_EMIT    = 3'd6;

	// Program addresses
	localparam logic [PC_WIDTH-1:0] P_IDLE   = 4'd0;
	localparam logic [PC_WIDTH-1:0] P_CHECK  = 4'd1;
	localparam logic [PC_WIDTH-1:0] P_SQTEST = 4'd2;
	localparam logic [PC_WIDTH-1:0] P_MRR    = 4'd3;
	localparam logic [PC_WIDTH-1:0] P_MII    = 4'd4;
	localparam logic [PC_WIDTH-1:0] P_MRI    = 4'd5;
	localparam logic [PC_WIDTH-1:0] P_SQWB   = 4'd6;
	localparam logic [PC_WIDTH-1:0] P_ADDC   = 4'd7;
	localparam logic [PC_WIDTH-1:0] P_NRR    = 4'd8;
	localparam logic [PC_WIDTH-1:0] P_NII    = 4'd9;
	localparam logic [PC_WIDTH-1:0] P_NCMP   = 4'd10;
	localparam logic [PC_WIDTH-1:0] P_DONE   = 4'd11;

	typedef struct packed {
		logic [1:0]          mul_sel;
		logic [1:0]          acc_op;
		logic [1:0]          n_op;
		logic [2:0]          cond;
		logic [PC_WIDTH-1:0] target;
	} ctrl_t;

	function automatic ctrl_t ucode(input logic [PC_WIDTH-1:0] pc);
		ctrl_t w;
		w = '{MUL_NONE, ACC_HOLD, N_HOLD, C_NEXT, P_IDLE};
		unique case (pc)
			P_IDLE:   w = '{MUL_NONE, ACC_HOLD,   N_HOLD,   C_WAIT_IN, P_IDLE};
			P_CHECK:  w = '{MUL_NONE, ACC_HOLD,   N_FROM_Z, C_LIMIT,   P_DONE};
			P_SQTEST: w = '{MUL_NONE, ACC_HOLD,   N_HOLD,   C_SQ_ZERO, P_ADDC};
			P_MRR:    w = '{MUL_RR,   ACC_HOLD,   N_HOLD,   C_NEXT,    P_IDLE};
			P_MII:    w = '{MUL_II,   ACC_LOAD,   N_HOLD,   C_NEXT,    P_IDLE};
			P_MRI:    w = '{MUL_RI,   ACC_SUB,    N_HOLD,   C_NEXT,    P_IDLE};
			P_SQWB:   w = '{MUL_NONE, ACC_HOLD,   N_SQ,     C_SQ_MORE, P_MRR};
			P_ADDC:   w = '{MUL_NONE, ACC_HOLD,   N_ADDC,   C_NEXT,    P_IDLE};
			P_NRR:    w = '{MUL_RR,   ACC_HOLD,   N_HOLD,   C_NEXT,    P_IDLE};
			P_NII:    w = '{MUL_II,   ACC_LOADSH, N_HOLD,   C_NEXT,    P_IDLE};
			P_NCMP:   w = '{MUL_NONE, ACC_HOLD,   N_HOLD,   C_INSIDE,  P_CHECK};
			P_DONE:   w = '{MUL_NONE, ACC_HOLD,   N_HOLD,   C_EMIT,    P_IDLE};
			default:  w = '{MUL_NONE, ACC_HOLD,   N_HOLD,   C_NEXT,    P_IDLE};
		endcase
		return w;
	endfunction

	// Clamp a wide signed value to the 32-bit signed range.
	function automatic logic signed [Q_WIDTH-1:0] sat_q(input logic signed [PROD_WIDTH-1:0] v);
		logic signed [Q_WIDTH-1:0] r;
		if (v[PROD_WIDTH-1:Q_WIDTH-1] == {(PROD_WIDTH-Q_WIDTH+1){v[PROD_WIDTH-1]}})
			r = v[Q_WIDTH-1:0];
		else
			r = {v[PROD_WIDTH-1], {(Q_WIDTH-1){~v[PROD_WIDTH-1]}}};
		return r;
	endfunction

endpackage

// ----- rtl/eti_if.sv -----
// Valid/ready channel interfaces for points, results and register writes.
// Depends on eti_pkg for field widths.
interface eti_in_if
	import eti_pkg::*;
();
	logic                              valid;
	logic                              ready;
	logic [COUNT_WIDTH-1:0]            start_count;
	logic signed [Q_WIDTH-1:0]         z_real;
	logic signed [Q_WIDTH-1:0]         z_imag;
	logic signed [Q_WIDTH-1:0]         c_real;
	logic signed [Q_WIDTH-1:0]         c_imag;
	modport source (output valid, start_count, z_real, z_imag, c_real, c_imag, input ready);
	modport sink   (input valid, start_count, z_real, z_imag, c_real, c_imag, output ready);
endinterface

interface eti_out_if
	import eti_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic [COUNT_WIDTH-1:0] escape_count;
	modport source (output valid, escape_count, input ready);
	modport sink   (input valid, escape_count, output ready);
endinterface

interface eti_cfg_if
	import eti_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/escape_time_fractal_iterator.sv -----
// Escape-time fractal iterator: microcoded sequencer around one 32x32 multiplier.
// Depends on eti_pkg and the channel interfaces in eti_if.sv.
//
//  channel  dir  moves                                       handshake
//  in_ch    in   start_count, z_real/imag, c_real/imag       valid/ready
//  out_ch   out  escape_count                                valid/ready
//  cfg      in   index, data (register write)                valid/ready, ready always high
//
// Each iteration runs S squarings, S being power_steps - 1 (or none), then adds c and checks
// the norm, all through the single shared multiplier. A request runs N iterations plus the
// final, failing check (the limit check if a limit is hit, else a full iteration).
// Reset loads the register defaults and parks the sequencer at the idle step.
// A finished result waits in the output register, so a stalled sink holds back only the
// request after next.
module escape_time_fractal_iterator
	import eti_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	eti_in_if.sink      in_ch,
	eti_out_if.source   out_ch,
	eti_cfg_if.sink     cfg
);

	logic [PS_WIDTH-1:0]    power_steps_q;
	logic [LIMIT_WIDTH-1:0] max_limit_q;
	logic [LIMIT_WIDTH-1:0] view_limit_q;

	logic [PC_WIDTH-1:0]    pc_q;
	logic [PS_WIDTH-1:0]    sq_cnt_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic signed [Q_WIDTH-1:0]    zr_q, zi_q, cr_q, ci_q, nr_q, ni_q;
	logic signed [PROD_WIDTH-1:0] prod_q, acc_q;

	logic                   out_valid_q;
	logic [COUNT_WIDTH-1:0] escape_count_q;

	ctrl_t                         ctl;
	logic                          in_acc;
	logic                          out_free;
	logic [PS_WIDTH-1:0]           squarings;
	logic [COUNT_WIDTH:0]          count_inc;
	logic                          limit_hit;
	logic signed [Q_WIDTH-1:0]     mul_a, mul_b;
	logic signed [PROD_WIDTH-1:0]  mul_p;
	logic signed [PROD_WIDTH-1:0]  norm;
	logic                          is_inside;
	logic signed [Q_WIDTH:0]       sum_r, sum_i;

	assign ctl       = ucode(pc_q);
	assign in_ch.ready = (ctl.cond == C_WAIT_IN);
	assign in_acc    = in_ch.valid && in_ch.ready;
	assign out_free  = !out_valid_q || out_ch.ready;
	assign cfg.ready = 1'b1;

	assign out_ch.valid        = out_valid_q;
	assign out_ch.escape_count = escape_count_q;

	assign squarings = (power_steps_q > PS_WIDTH'(1)) ? power_steps_q - PS_WIDTH'(1)
	                                                  : '0;
	assign count_inc = {1'b0, count_q} + (COUNT_WIDTH+1)'(1);
	assign limit_hit = (count_inc > {1'b0, max_limit_q}) || (count_inc > {1'b0, view_limit_q});

	always_comb begin
		case (ctl.mul_sel)
			MUL_RR: begin
				mul_a = nr_q;
				mul_b = nr_q;
			end
			MUL_II: begin
				mul_a = ni_q;
				mul_b = ni_q;
			end
			default: begin
				mul_a = nr_q;
				mul_b = ni_q;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Both terms are non-negative squares, each rounded down before the sum.
	assign norm      = acc_q + (prod_q >>> FRAC_BITS);
	assign is_inside = (norm <= (PROD_WIDTH'(4) <<< FRAC_BITS));

	assign sum_r = {nr_q[Q_WIDTH-1], nr_q} + {cr_q[Q_WIDTH-1], cr_q};
	assign sum_i = {ni_q[Q_WIDTH-1], ni_q} + {ci_q[Q_WIDTH-1], ci_q};

	// Configuration registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_steps_q <= PS_RESET;
			max_limit_q   <= MAX_RESET;
			view_limit_q  <= VIEW_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_POWER_STEPS: power_steps_q <= cfg.data[PS_WIDTH-1:0];
				REG_MAX_LIMIT:   max_limit_q   <= cfg.data[LIMIT_WIDTH-1:0];
				REG_VIEW_LIMIT:  view_limit_q  <= cfg.data[LIMIT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= P_IDLE;
		end else begin
			unique case (ctl.cond)
				C_WAIT_IN: if (in_acc) pc_q <= pc_q + PC_WIDTH'(1);
				C_LIMIT:   pc_q <= limit_hit ? ctl.target : pc_q + PC_WIDTH'(1);
				C_SQ_ZERO: pc_q <= (sq_cnt_q == '0) ? ctl.target : pc_q + PC_WIDTH'(1);
				C_SQ_MORE: pc_q <= (sq_cnt_q != PS_WIDTH'(1)) ? ctl.target : pc_q + PC_WIDTH'(1);
				C_INSIDE:  pc_q <= is_inside ? ctl.target : pc_q + PC_WIDTH'(1);
				C_EMIT:    if (out_free) pc_q <= ctl.target;
				default:   pc_q <= pc_q + PC_WIDTH'(1);
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			count_q <= in_ch.start_count;
			zr_q    <= in_ch.z_real;
			zi_q    <= in_ch.z_imag;
			cr_q    <= in_ch.c_real;
			ci_q    <= in_ch.c_imag;
		end
		if (ctl.cond == C_INSIDE && is_inside) begin
			count_q <= count_inc[COUNT_WIDTH-1:0];
			zr_q    <= nr_q;
			zi_q    <= ni_q;
		end

		if (ctl.mul_sel != MUL_NONE)
			prod_q <= mul_p;

		case (ctl.acc_op)
			ACC_LOAD:   acc_q <= prod_q;
			ACC_SUB:    acc_q <= acc_q - prod_q;
			ACC_LOADSH: acc_q <= prod_q >>> FRAC_BITS;
			default: ;
		endcase

		case (ctl.n_op)
			N_FROM_Z: begin
				nr_q     <= zr_q;
				ni_q     <= zi_q;
				sq_cnt_q <= squarings;
			end
			N_SQ: begin
				// Real part from re*re - im*im, imaginary from 2*re*im via one shift less.
				nr_q     <= sat_q(acc_q >>> FRAC_BITS);
				ni_q     <= sat_q(prod_q >>> (FRAC_BITS - 1));
				sq_cnt_q <= sq_cnt_q - PS_WIDTH'(1);
			end
			N_ADDC: begin
				nr_q <= sat_q(PROD_WIDTH'(sum_r));
				ni_q <= sat_q(PROD_WIDTH'(sum_i));
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.cond == C_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cond == C_EMIT && out_free)
			escape_count_q <= count_q;
	end

endmodule

// ----- tb/sv/escape_time_fractal_iterator_tb.sv -----
// Self-checking testbench for the escape-time fractal iterator: directed and random points
// under several register settings, with every escape count checked against a local predictor.
// Depends on eti_pkg, the channel interfaces in eti_if.sv and the escape_time_fractal_iterator RTL.
module escape_time_fractal_iterator_tb;
	import eti_pkg::*;

	localparam int CYCLE_LIMIT = 2_500_000; // roughly five times the slowest legal run
	localparam int LONG_HOLD   = 3000;
	localparam int HOLD_AT     = 40;         // result number at which the long stall starts
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam longint Q_HI = 2147483647;
	localparam longint Q_LO = -longint'(2147483647) - 1;

	localparam logic signed [Q_WIDTH-1:0] Q_ZERO = 32'sh0000_0000;
	localparam logic signed [Q_WIDTH-1:0] Q_ONE  = 32'sh1000_0000;
	localparam logic signed [Q_WIDTH-1:0] Q_TWO  = 32'sh2000_0000;
	localparam logic signed [Q_WIDTH-1:0] Q_MAXV = 32'sh7FFF_FFFF;
	localparam logic signed [Q_WIDTH-1:0] Q_MINV = 32'sh8000_0000;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0]    start_count;
		logic signed [Q_WIDTH-1:0] z_real;
		logic signed [Q_WIDTH-1:0] z_imag;
		logic signed [Q_WIDTH-1:0] c_real;
		logic signed [Q_WIDTH-1:0] c_imag;
	} point_t;

	logic clk;
	logic arst_n;

	eti_in_if  in_ch();
	eti_out_if out_ch();
	eti_cfg_if cfg_ch();

	escape_time_fractal_iterator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the configuration registers.
	logic [PS_WIDTH-1:0]    power_steps_sh = PS_RESET;
	logic [LIMIT_WIDTH-1:0] max_limit_sh   = MAX_RESET;
	logic [LIMIT_WIDTH-1:0] view_limit_sh  = VIEW_RESET;

	point_t                 point_q[$];
	logic [COUNT_WIDTH-1:0] escape_count_q[$];
	point_t                 point_on_bus;

	int in_idle_pct   = 0;
	int out_idle_pct  = 0;
	int in_gap_left   = 0;
	int out_hold_left = 0;
	int results_seen  = 0;
	int error_count   = 0;
	int cycle_count   = 0;
	bit long_hold_done = 1'b0;

	function automatic longint clamp_q(input longint v);
		if (v > Q_HI)
			return Q_HI;
		if (v < Q_LO)
			return Q_LO;
		return v;
	endfunction

	// Iterates one point under the current register settings and returns the count at which
	// it escapes or meets a limit.
	function automatic logic [COUNT_WIDTH-1:0] predict_escape_count(input point_t p);
		longint zr, zi, nr, ni, cr, ci, re_sq, norm;
		int unsigned count, squarings;
		bit running;
		zr = $signed(p.z_real);
		zi = $signed(p.z_imag);
		cr = $signed(p.c_real);
		ci = $signed(p.c_imag);
		count = p.start_count;
		squarings = (power_steps_sh > 1) ? power_steps_sh - 1 : 0;
		running = 1'b1;
		while (running) begin
			nr = zr;
			ni = zi;
			for (int k = 0; k < squarings; k++) begin
				re_sq = clamp_q((nr * nr - ni * ni) >>> FRAC_BITS);
				ni = clamp_q((nr * ni) >>> (FRAC_BITS - 1));
				nr = re_sq;
			end
			nr = clamp_q(nr + cr);
			ni = clamp_q(ni + ci);
			norm = ((nr * nr) >>> FRAC_BITS) + ((ni * ni) >>> FRAC_BITS);
			if (count + 1 <= max_limit_sh && count + 1 <= view_limit_sh &&
					norm <= (longint'(4) << FRAC_BITS)) begin
				count++;
				zr = nr;
				zi = ni;
			end else begin
				running = 1'b0;
			end
		end
		return COUNT_WIDTH'(count);
	endfunction

	function automatic point_t make_point(input logic [COUNT_WIDTH-1:0] sc,
			input logic signed [Q_WIDTH-1:0] zr, input logic signed [Q_WIDTH-1:0] zi,
			input logic signed [Q_WIDTH-1:0] cr, input logic signed [Q_WIDTH-1:0] ci);
		point_t p;
		p.start_count = sc;
		p.z_real = zr;
		p.z_imag = zi;
		p.c_real = cr;
		p.c_imag = ci;
		return p;
	endfunction

	// Most points lie around the set with a small or zero start value; the rest are raw noise.
	// With near_top set the start count sits at or just below the top of its range.
	function automatic point_t random_point(input bit near_top);
		point_t p;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			p.c_real = Q_WIDTH'(-671088640 + $urandom_range(0, 1073741824));
			p.c_imag = Q_WIDTH'(-402653184 + $urandom_range(0, 805306368));
			if ($urandom_range(0, 99) < 60) begin
				p.z_real = Q_ZERO;
				p.z_imag = Q_ZERO;
			end else begin
				p.z_real = Q_WIDTH'(-134217728 + $urandom_range(0, 268435456));
				p.z_imag = Q_WIDTH'(-134217728 + $urandom_range(0, 268435456));
			end
		end else begin
			p.c_real = $urandom;
			p.c_imag = $urandom;
			p.z_real = $urandom;
			p.z_imag = $urandom;
		end
		pick = $urandom_range(0, 99);
		if (near_top)
			p.start_count = COUNT_WIDTH'(65535 - $urandom_range(0, 40));
		else if (pick < 80)
			p.start_count = '0;
		else if (pick < 90)
			p.start_count = COUNT_WIDTH'($urandom_range(0, 60));
		else
			p.start_count = COUNT_WIDTH'($urandom);
		return p;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			REG_POWER_STEPS: power_steps_sh = value[PS_WIDTH-1:0];
			REG_MAX_LIMIT:   max_limit_sh   = value[LIMIT_WIDTH-1:0];
			REG_VIEW_LIMIT:  view_limit_sh  = value[LIMIT_WIDTH-1:0];
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
	endtask

	// Looks between rising edges, once the driver and monitor have settled.
	task automatic wait_drained(input int settle);
		while (point_q.size() != 0 || in_ch.valid || escape_count_q.size() != 0)
			@(negedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic run_phase(input logic [CFG_DATA_W-1:0] ps, input logic [CFG_DATA_W-1:0] max_lim,
			input logic [CFG_DATA_W-1:0] view_lim, input int n, input bit near_top,
			input int in_pct, input int out_pct);
		write_reg(REG_POWER_STEPS, ps);
		write_reg(REG_MAX_LIMIT, max_lim);
		write_reg(REG_VIEW_LIMIT, view_lim);
		in_idle_pct  = in_pct;
		out_idle_pct = out_pct;
		for (int i = 0; i < n; i++)
			point_q.push_back(random_point(near_top));
		wait_drained(8);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.start_count = '0;
		in_ch.z_real = '0;
		in_ch.z_imag = '0;
		in_ch.c_real = '0;
		in_ch.c_imag = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		forever #5 clk = ~clk;
	end

	// Driver: one request at a time from point_q, with random bursts of idle cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_gap_left = 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				escape_count_q.push_back(predict_escape_count(point_on_bus));
			if (!in_ch.valid || in_ch.ready) begin
				if (in_gap_left > 0) begin
					in_gap_left--;
					in_ch.valid <= 1'b0;
				end else if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
					in_gap_left = $urandom_range(1, 13) - 1;
					in_ch.valid <= 1'b0;
				end else if (point_q.size() != 0) begin
					point_on_bus = point_q.pop_front();
					in_ch.valid       <= 1'b1;
					in_ch.start_count <= point_on_bus.start_count;
					in_ch.z_real      <= point_on_bus.z_real;
					in_ch.z_imag      <= point_on_bus.z_imag;
					in_ch.c_real      <= point_on_bus.c_real;
					in_ch.c_imag      <= point_on_bus.c_imag;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each escape count and stalls the result channel at random. Once, a long
	// stall lets the block fill up so that it has to hold off further requests.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			out_hold_left = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (escape_count_q.size() == 0) begin
					error_count++;
					$display("%0t: escape count %0d arrived with no request outstanding",
						$time, out_ch.escape_count);
				end else if (out_ch.escape_count !== escape_count_q[0]) begin
					error_count++;
					$display("%0t: escape_count mismatch: expected %0d, actual %0d",
						$time, escape_count_q[0], out_ch.escape_count);
					void'(escape_count_q.pop_front());
				end else begin
					void'(escape_count_q.pop_front());
				end
			end
			if (out_hold_left > 0) begin
				out_hold_left--;
				out_ch.ready <= 1'b0;
			end else if (!long_hold_done && results_seen >= HOLD_AT) begin
				long_hold_done = 1'b1;
				out_hold_left = LONG_HOLD - 1;
				out_ch.ready <= 1'b0;
			end else if (out_idle_pct > 0 && $urandom_range(0, 99) < out_idle_pct) begin
				out_hold_left = $urandom_range(1, 13) - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed points under the reset settings.
		in_idle_pct  = 25;
		out_idle_pct = 25;
		point_q.push_back(make_point(16'd0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO));
		point_q.push_back(make_point(16'd0, Q_ZERO, Q_ZERO, -Q_TWO, Q_ZERO));
		point_q.push_back(make_point(16'd0, Q_ZERO, Q_ZERO, Q_TWO, Q_ZERO));
		point_q.push_back(make_point(16'd0, Q_ZERO, Q_ZERO, Q_ZERO, Q_TWO));
		point_q.push_back(make_point(16'd0, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO));
		point_q.push_back(make_point(16'd0, Q_ZERO, Q_ZERO, Q_MAXV, Q_MAXV));
		point_q.push_back(make_point(16'd0, Q_ZERO, Q_ZERO, Q_MINV, Q_MINV));
		point_q.push_back(make_point(16'd0, Q_MAXV, Q_MAXV, Q_ZERO, Q_ZERO));
		point_q.push_back(make_point(16'd0, Q_MINV, Q_MINV, Q_MINV, Q_MINV));
		point_q.push_back(make_point(16'd0, Q_MINV, Q_MAXV, Q_MAXV, Q_MINV));
		point_q.push_back(make_point(16'd50, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO));
		point_q.push_back(make_point(16'd49, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO));
		point_q.push_back(make_point(16'hFFFF, Q_MAXV, Q_MINV, Q_MAXV, Q_MINV));
		point_q.push_back(make_point(16'hFFFE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO));
		point_q.push_back(make_point(16'd0, Q_ZERO, Q_ZERO, 32'sh0400_0000, Q_ZERO));
		point_q.push_back(make_point(16'd0, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE));
		point_q.push_back(make_point(16'd0, Q_ZERO, Q_ZERO, -32'sh0C00_0000, 32'sh0199_999A));
		// Tiny negative values exercise rounding toward minus infinity.
		point_q.push_back(make_point(16'd0, 32'shFFFF_FFFF, 32'shFFFF_FFFF,
			32'sh0000_0001, 32'shFFFF_FFFF));
		point_q.push_back(make_point(16'd0, 32'sh0000_4000, -32'sh0000_4000,
			32'shAAAA_AAAA, 32'sh5555_5555));
		point_q.push_back(make_point(16'd7, Q_ONE, -Q_ONE, 32'sh5555_5555, 32'shAAAA_AAAA));
		wait_drained(8);

		// A write to the unused index, which the block drops; the phase after it rewrites every register.
		write_reg(REG_UNUSED, 16'h0005);
		run_phase(16'd1, 16'd300, 16'd200, 80, 1'b0, 20, 20);
		// Only the low bits of the data word reach the power register.
		run_phase(16'hFFF3, 16'd100, 16'd60, 80, 1'b0, 0, 0);
		run_phase(16'd0, 16'd40, 16'd65535, 60, 1'b0, 30, 10);
		run_phase(16'd8, 16'd30, 16'd30, 60, 1'b0, 10, 30);
		run_phase(16'd15, 16'd65535, 16'd12, 50, 1'b0, 20, 20);
		run_phase(16'd4, 16'd0, 16'd100, 40, 1'b0, 30, 30);
		run_phase(16'd2, 16'd65535, 16'd65535, 60, 1'b1, 15, 15);
		run_phase(16'd5, 16'd500, 16'd25, 80, 1'b0, 25, 5);
		run_phase(16'd2, 16'd64, 16'd64, 60, 1'b0, 0, 0);

		repeat (64) @(posedge clk);
		if (error_count == 0 && escape_count_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/eti_pkg.sv
rtl/eti_if.sv
rtl/escape_time_fractal_iterator.sv
tb/sv/escape_time_fractal_iterator_tb.sv
